@@ hw/rtl/sat_pkg.sv @@
// Shared constants, codes and types of the session admission table.
package sat_pkg;

  localparam int ACTIVE_DEPTH = 16;
  localparam int WAIT_DEPTH   = 16;
  localparam int ID_WIDTH     = 64;

  localparam int CNT_W  = $clog2(ACTIVE_DEPTH + 1);
  localparam int FILL_W = $clog2(WAIT_DEPTH + 1);
  localparam int PTR_W  = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
  localparam int LIM_W  = (CNT_W > 5) ? CNT_W : 5;

  localparam logic OP_CONNECT    = 1'b0;
  localparam logic OP_DISCONNECT = 1'b1;

  typedef enum logic [2:0] {
    ST_ADMITTED  = 3'd0,
    ST_QUEUED    = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_WAIT_FULL = 3'd3,
    ST_REMOVED   = 3'd4,
    ST_NOT_FOUND = 3'd5
  } status_t;

  typedef struct packed {
    logic [ID_WIDTH-1:0] key;
    logic                place;
    logic                clear;
  } cell_cmd_t;

  typedef struct packed {
    logic free;
    logic hit;
  } cell_link_t;

endpackage

@@ hw/rtl/sat_if.sv @@
// Request and response channel interfaces of the session admission table.
interface sat_req_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [63:0] session_id;

  modport source (output valid, output operation, output session_id, input ready);
  modport sink (input valid, input operation, input session_id, output ready);
endinterface

interface sat_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        promoted_valid;
  logic [63:0] promoted_id;
  logic [4:0]  active_count;
  logic [4:0]  waiting_count;

  modport source (output valid, output status, output promoted_valid, output promoted_id,
                  output active_count, output waiting_count, input ready);
  modport sink (input valid, input status, input promoted_valid, input promoted_id,
                input active_count, input waiting_count, output ready);
endinterface

@@ hw/rtl/sat_cell.sv @@
// One active-table cell: holds an id, compares it, claims the first free slot in the row.
module sat_cell
  import sat_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cell_cmd_t  cmd,
  input  cell_link_t link_in,
  output cell_link_t link_out,
  output logic       valid
);

  logic [ID_WIDTH-1:0] id;
  logic                match;
  logic                claim;

  assign match = valid && (id == cmd.key);
  assign claim = cmd.place && !link_in.free && !valid;

  assign link_out.free = link_in.free | ~valid;
  assign link_out.hit  = link_in.hit | match;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.clear && match) begin
      valid <= 1'b0;
    end else if (claim) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (claim) begin
      id <= cmd.key;
    end
  end

endmodule

@@ hw/rtl/sat_wait_queue.sv @@
// FIFO of waiting session ids with a registered head read.
module sat_wait_queue
  import sat_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic [ID_WIDTH-1:0] push_id,
  input  logic                pop,
  output logic [ID_WIDTH-1:0] head_id,
  output logic [FILL_W-1:0]   fill
);

  logic [ID_WIDTH-1:0] mem [WAIT_DEPTH];
  logic [PTR_W-1:0]    head;
  logic [PTR_W-1:0]    tail;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(WAIT_DEPTH - 1)) begin
      return '0;
    end
    return p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      mem[tail] <= push_id;
    end
    head_id <= mem[head];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        tail <= ptr_inc(tail);
      end
      if (pop) begin
        head <= ptr_inc(head);
      end
      if (push && !pop) begin
        fill <= fill + FILL_W'(1);
      end else if (pop && !push) begin
        fill <= fill - FILL_W'(1);
      end
    end
  end

endmodule

@@ hw/rtl/session_admission_table.sv @@
// Session admission table: a row of active-id cells plus a FIFO wait queue.
// A request is taken in S_IDLE, evaluated in S_EVAL and, if a disconnect promotes a waiter,
// given an S_PROMOTE pass; the last pass registers the response once any held one is taken,
// and no new request is taken meanwhile. Each pass is one id broadcast over the cell row with
// a match and first-free chain, then a commit. Reset (synchronous): cell valid bits, active
// count, queue pointers and fill cleared, max_active set to 16; no clearing pass is needed.
module session_admission_table
  import sat_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [4:0]      cfg_data,
  sat_req_if.sink         req,
  sat_rsp_if.source       rsp
);

  typedef enum logic [1:0] {S_IDLE, S_EVAL, S_PROMOTE} state_t;

  state_t              state;
  logic                op_q;
  logic [ID_WIDTH-1:0] id_q;
  logic [4:0]          max_active;
  logic [CNT_W-1:0]    active_cnt;

  cell_cmd_t           cmd;
  cell_link_t          link [ACTIVE_DEPTH+1];
  logic [ACTIVE_DEPTH-1:0] cell_valid;

  logic [ID_WIDTH-1:0] head_id;
  logic [FILL_W-1:0]   fill;
  logic [FILL_W-1:0]   fill_next;
  logic [CNT_W-1:0]    active_cnt_next;
  logic [LIM_W-1:0]    limit;
  logic                hit;
  logic                at_limit;
  logic                wait_full;
  logic                promote;
  logic                out_free;
  logic                go;
  logic                emit;
  logic                push;
  logic                pop;
  logic                place;
  logic                remove;
  status_t             status_next;

  assign limit = (LIM_W'(max_active) > LIM_W'(ACTIVE_DEPTH)) ? LIM_W'(ACTIVE_DEPTH)
                                                            : LIM_W'(max_active);
  assign hit       = link[ACTIVE_DEPTH].hit;
  assign at_limit  = LIM_W'(active_cnt) >= limit;
  assign wait_full = fill == FILL_W'(WAIT_DEPTH);
  assign out_free  = !rsp.valid || rsp.ready;
  assign promote   = (op_q == OP_DISCONNECT) && hit && (fill != '0) &&
                     (LIM_W'(active_cnt - CNT_W'(1)) < limit);

  assign go = ((state == S_EVAL) && (promote || out_free)) ||
              ((state == S_PROMOTE) && out_free);
  assign emit = go && (((state == S_EVAL) && !promote) || (state == S_PROMOTE));

  assign push   = go && (state == S_EVAL) && (op_q == OP_CONNECT) && at_limit && !wait_full;
  assign pop    = go && (state == S_PROMOTE);
  assign remove = go && (state == S_EVAL) && (op_q == OP_DISCONNECT) && hit;
  assign place  = go && !hit && (((state == S_EVAL) && (op_q == OP_CONNECT) && !at_limit) ||
                                 (state == S_PROMOTE));

  assign cmd.key   = (state == S_PROMOTE) ? head_id : id_q;
  assign cmd.place = place;
  assign cmd.clear = remove;

  assign link[0] = '{free: 1'b0, hit: 1'b0};

  for (genvar i = 0; i < ACTIVE_DEPTH; i++) begin : g_cell
    sat_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .cmd      (cmd),
      .link_in  (link[i]),
      .link_out (link[i+1]),
      .valid    (cell_valid[i])
    );
  end

  sat_wait_queue u_wait_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_id (id_q),
    .pop     (pop),
    .head_id (head_id),
    .fill    (fill)
  );

  always_comb begin
    active_cnt_next = active_cnt;
    if (place) begin
      active_cnt_next = active_cnt + CNT_W'(1);
    end else if (remove) begin
      active_cnt_next = active_cnt - CNT_W'(1);
    end
    fill_next = fill;
    if (push) begin
      fill_next = fill + FILL_W'(1);
    end else if (pop) begin
      fill_next = fill - FILL_W'(1);
    end
    if (op_q == OP_DISCONNECT) begin
      status_next = hit ? ST_REMOVED : ST_NOT_FOUND;
    end else if (at_limit) begin
      status_next = wait_full ? ST_WAIT_FULL : ST_QUEUED;
    end else begin
      status_next = hit ? ST_DUPLICATE : ST_ADMITTED;
    end
  end

  assign req.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      max_active <= 5'd16;
      active_cnt <= '0;
      rsp.valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_active <= cfg_data;
      end
      active_cnt <= active_cnt_next;
      if (emit) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (go) begin
            if (promote) begin
              state <= S_PROMOTE;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_PROMOTE: begin
          if (go) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
    if (req.valid && req.ready) begin
      op_q <= req.operation;
      id_q <= req.session_id[ID_WIDTH-1:0];
    end
    if (go && (state == S_EVAL) && !promote) begin
      rsp.status         <= status_next;
      rsp.promoted_valid <= 1'b0;
      rsp.promoted_id    <= '0;
      rsp.active_count   <= 5'(active_cnt_next);
      rsp.waiting_count  <= 5'(fill_next);
    end else if (go && (state == S_PROMOTE)) begin
      rsp.status         <= ST_REMOVED;
      rsp.promoted_valid <= !hit;
      rsp.promoted_id    <= hit ? '0 : 64'(head_id);
      rsp.active_count   <= 5'(active_cnt_next);
      rsp.waiting_count  <= 5'(fill_next);
    end
  end

  a_count_matches_cells: assert property (@(posedge clk) disable iff (rst)
    $countones(cell_valid) == 32'(active_cnt))
    else $error("active count differs from valid cells");

  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    32'(active_cnt) <= ACTIVE_DEPTH)
    else $error("active count above table depth");

  a_queue_bounds: assert property (@(posedge clk) disable iff (rst)
    !(push && wait_full) && !(pop && (fill == '0)))
    else $error("wait queue overflow or underflow");

  a_promote_has_waiter: assert property (@(posedge clk) disable iff (rst)
    (state == S_PROMOTE) |-> (fill != '0))
    else $error("promotion without a waiter");

  a_promote_follows_eval: assert property (@(posedge clk) disable iff (rst)
    ((state == S_EVAL) && go && promote) |=> (state == S_PROMOTE) && !rsp.valid ||
    (state == S_PROMOTE))
    else $error("promotion pass skipped");

endmodule

@@ sim/tb_session_admission_table.sv @@
// Self-checking testbench of the session admission table: directed table, then random phases.
module tb_session_admission_table;
  import sat_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int POOL_SIZE   = 20;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 115;

  typedef struct packed {
    status_t     status;
    logic        promoted_valid;
    logic [63:0] promoted_id;
    logic [4:0]  active_count;
    logic [4:0]  waiting_count;
  } outcome_t;

  typedef struct {
    bit          is_cfg;
    logic [4:0]  cfg_val;
    logic        op;
    logic [63:0] id;
    bit          typed;
    outcome_t    want;
  } plan_row_t;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [4:0] cfg_data;

  sat_req_if req();
  sat_rsp_if rsp();

  session_admission_table i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .req      (req),
    .rsp      (rsp)
  );

  // predictor state
  logic [63:0]       sess_ids   [ACTIVE_DEPTH];
  bit                sess_live  [ACTIVE_DEPTH];
  logic [63:0]       waiters    [WAIT_DEPTH];
  int unsigned       wait_rd;
  int unsigned       wait_wr;
  int unsigned       wait_cnt;
  logic [4:0]        limit_reg;

  outcome_t          expected_outcomes [$];
  plan_row_t         plan [$];
  logic [63:0]       id_pool [POOL_SIZE];
  logic [4:0]        phase_limits [PHASES] = '{5'd16, 5'd1, 5'd3, 5'd0, 5'd31, 5'd8, 5'd2,
                                               5'd16, 5'd5, 5'd12, 5'd1, 5'd17};

  int                mismatches = 0;
  int                cycles = 0;
  int                send_idle_pct;
  int                stall_pct;
  int                hold_req;
  int                hold_left = 0;
  bit                hold_taken = 1'b0;
  outcome_t          seen;
  outcome_t          want;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int live_count();
    int n;
    n = 0;
    for (int i = 0; i < ACTIVE_DEPTH; i++) if (sess_live[i]) n++;
    return n;
  endfunction

  function automatic int lookup_session(logic [63:0] id);
    for (int i = 0; i < ACTIVE_DEPTH; i++) if (sess_live[i] && sess_ids[i] == id) return i;
    return -1;
  endfunction

  function automatic void insert_session(logic [63:0] id);
    for (int i = 0; i < ACTIVE_DEPTH; i++) begin
      if (!sess_live[i]) begin
        sess_live[i] = 1'b1;
        sess_ids[i]  = id;
        return;
      end
    end
  endfunction

  function automatic outcome_t predict_session(logic op, logic [63:0] id);
    outcome_t    r;
    int          lim;
    int          slot;
    logic [63:0] w;
    r   = '0;
    lim = (limit_reg > ACTIVE_DEPTH) ? ACTIVE_DEPTH : int'(limit_reg);
    if (op == OP_CONNECT) begin
      if (live_count() >= lim) begin
        if (wait_cnt >= WAIT_DEPTH) begin
          r.status = ST_WAIT_FULL;
        end else begin
          waiters[wait_wr] = id;
          wait_wr = (wait_wr + 1) % WAIT_DEPTH;
          wait_cnt++;
          r.status = ST_QUEUED;
        end
      end else if (lookup_session(id) >= 0) begin
        r.status = ST_DUPLICATE;
      end else begin
        insert_session(id);
        r.status = ST_ADMITTED;
      end
    end else begin
      slot = lookup_session(id);
      if (slot < 0) begin
        r.status = ST_NOT_FOUND;
      end else begin
        sess_live[slot] = 1'b0;
        r.status = ST_REMOVED;
        if (wait_cnt > 0 && live_count() < lim) begin
          w = waiters[wait_rd];
          wait_rd = (wait_rd + 1) % WAIT_DEPTH;
          wait_cnt--;
          // a waiter that is already active is dropped
          if (lookup_session(w) < 0) begin
            insert_session(w);
            r.promoted_valid = 1'b1;
            r.promoted_id    = w;
          end
        end
      end
    end
    r.active_count  = 5'(live_count());
    r.waiting_count = 5'(wait_cnt);
    return r;
  endfunction

  task automatic add_req(logic op, logic [63:0] id);
    plan_row_t row;
    row = '{is_cfg: 1'b0, cfg_val: '0, op: op, id: id, typed: 1'b0, want: '0};
    plan.insert(plan.size(), row);
  endtask

  task automatic add_chk(logic op, logic [63:0] id, status_t st, logic pv, logic [63:0] pid,
                         int ac, int wc);
    plan_row_t row;
    row = '{is_cfg: 1'b0, cfg_val: '0, op: op, id: id, typed: 1'b1, want: '0};
    row.want = '{status: st, promoted_valid: pv, promoted_id: pid,
                 active_count: 5'(ac), waiting_count: 5'(wc)};
    plan.insert(plan.size(), row);
  endtask

  task automatic add_cfg(logic [4:0] v);
    plan_row_t row;
    row = '{is_cfg: 1'b1, cfg_val: v, op: 1'b0, id: '0, typed: 1'b0, want: '0};
    plan.insert(plan.size(), row);
  endtask

  task automatic issue_request(logic op, logic [63:0] id, bit typed, outcome_t typed_want);
    outcome_t p;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid      <= 1'b1;
    req.operation  <= op;
    req.session_id <= id;
    do @(posedge clk); while (!req.ready);
    p = predict_session(op, id);
    expected_outcomes.insert(expected_outcomes.size(), typed ? typed_want : p);
  endtask

  task automatic drain_requests();
    @(negedge clk);
    req.valid <= 1'b0;
    while (expected_outcomes.size() != 0) @(posedge clk);
  endtask

  task automatic write_limit(logic [4:0] v);
    drain_requests();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_data  <= v;
    limit_reg = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // receiver: random stalls plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_req > 0 && !hold_taken) begin
      hold_left  = hold_req;
      hold_taken = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) begin
      seen.status         = status_t'(rsp.status);
      seen.promoted_valid = rsp.promoted_valid;
      seen.promoted_id    = rsp.promoted_id;
      seen.active_count   = rsp.active_count;
      seen.waiting_count  = rsp.waiting_count;
      if (expected_outcomes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("response with no request pending: status %0d active %0d waiting %0d",
                   rsp.status, rsp.active_count, rsp.waiting_count);
      end else begin
        want = expected_outcomes.pop_front();
        if (seen.status !== want.status || seen.promoted_valid !== want.promoted_valid ||
            seen.promoted_id !== want.promoted_id ||
            seen.active_count !== want.active_count ||
            seen.waiting_count !== want.waiting_count) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch (exp/got): status %0d/%0d promoted %0b/%0b id %h/%h ",
                      "active %0d/%0d waiting %0d/%0d"},
                     want.status, seen.status, want.promoted_valid, seen.promoted_valid,
                     want.promoted_id, seen.promoted_id, want.active_count,
                     seen.active_count, want.waiting_count, seen.waiting_count);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    logic        op;
    logic [63:0] id;
    outcome_t    blank;
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_data       = '0;
    req.valid      = 1'b0;
    req.operation  = 1'b0;
    req.session_id = '0;
    send_idle_pct  = 0;
    stall_pct      = 0;
    hold_req       = 0;
    blank          = '0;
    limit_reg      = 5'd16;
    wait_rd        = 0;
    wait_wr        = 0;
    wait_cnt       = 0;
    for (int i = 0; i < ACTIVE_DEPTH; i++) begin
      sess_live[i] = 1'b0;
      sess_ids[i]  = '0;
    end
    for (int i = 0; i < WAIT_DEPTH; i++) waiters[i] = '0;
    id_pool[0] = '0;
    id_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) id_pool[i] = {$urandom, $urandom};

    add_chk(OP_CONNECT, 64'h0, ST_ADMITTED, 1'b0, 64'h0, 1, 0);
    add_chk(OP_CONNECT, '1, ST_ADMITTED, 1'b0, 64'h0, 2, 0);
    add_chk(OP_CONNECT, 64'h0, ST_DUPLICATE, 1'b0, 64'h0, 2, 0);
    add_chk(OP_DISCONNECT, 64'h1234, ST_NOT_FOUND, 1'b0, 64'h0, 2, 0);
    add_cfg(5'd2);
    add_chk(OP_CONNECT, 64'h0, ST_QUEUED, 1'b0, 64'h0, 2, 1);
    add_chk(OP_CONNECT, 64'h5, ST_QUEUED, 1'b0, 64'h0, 2, 2);
    // head waiter is still active: dropped
    add_chk(OP_DISCONNECT, '1, ST_REMOVED, 1'b0, 64'h0, 1, 1);
    // promotion into an empty table
    add_chk(OP_DISCONNECT, 64'h0, ST_REMOVED, 1'b1, 64'h5, 1, 0);
    add_cfg(5'd0);
    add_chk(OP_CONNECT, 64'h9, ST_QUEUED, 1'b0, 64'h0, 1, 1);
    add_chk(OP_DISCONNECT, 64'h5, ST_REMOVED, 1'b0, 64'h0, 0, 1);
    for (int i = 0; i < WAIT_DEPTH - 1; i++) add_req(OP_CONNECT, 64'h100 + i);
    add_chk(OP_CONNECT, 64'hAAAA_AAAA_AAAA_AAAA, ST_WAIT_FULL, 1'b0, 64'h0, 0, 16);
    add_cfg(5'd31);
    add_chk(OP_CONNECT, 64'h5555_5555_5555_5555, ST_ADMITTED, 1'b0, 64'h0, 1, 16);
    add_chk(OP_DISCONNECT, 64'h5555_5555_5555_5555, ST_REMOVED, 1'b1, 64'h9, 1, 15);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) write_limit(plan[i].cfg_val);
      else issue_request(plan[i].op, plan[i].id, plan[i].typed, plan[i].want);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      write_limit(phase_limits[ph]);
      @(posedge clk);
      case (ph % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 49;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 49;
        end
        default: begin
          send_idle_pct = 19;
          stall_pct     = 19;
        end
      endcase
      if (ph == 2) hold_req = 400;
      repeat (PHASE_ITEMS) begin
        op = ($urandom_range(0, 99) < 45) ? OP_DISCONNECT : OP_CONNECT;
        id = ($urandom_range(0, 99) < 85) ? id_pool[$urandom_range(0, POOL_SIZE - 1)]
                                          : {$urandom, $urandom};
        issue_request(op, id, 1'b0, blank);
      end
    end

    drain_requests();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ session_admission_table.f @@
hw/rtl/sat_pkg.sv
hw/rtl/sat_if.sv
hw/rtl/sat_cell.sv
hw/rtl/sat_wait_queue.sv
hw/rtl/session_admission_table.sv
sim/tb_session_admission_table.sv
